@@ sv/itrt_pkg.sv @@
package itrt_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int RADIX_W         = 6;
   localparam int CHAR_W          = 8;
   localparam int DIGIT_W         = 6;
   localparam int STEP_BITS       = 8;   // quotient bits resolved per divider cycle
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [CHAR_W-1:0]  CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0]  CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0]  CH_MINUS   = 8'h2D;
   localparam logic [RADIX_W-1:0] DEC_BASE   = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_SIGN,
      S_READ,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic                neg;
      logic [RADIX_W-1:0]  radix;
   } job_ctl_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dw;
      dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < DIGIT_W'(DEC_BASE)) begin
         return CH_ZERO + dw;
      end
      return CH_LOWER_A + dw - CHAR_W'(DEC_BASE);
   endfunction

endpackage

@@ sv/integer_to_radix_text.sv @@
// Integer to ASCII text in base 2..36. A request transaction carries a signed value and a
// radix; the block answers with one response transaction per character, most significant
// first, rsp_last marking the final one. Digits above nine are lower-case letters, zero is
// a single '0'. Base ten is signed (leading '-', the most negative value prints as its
// magnitude); every other base prints the raw unsigned bit pattern. A radix below 2 is
// treated as 2 and one above 36 as 36. The digit divider resolves each digit at 8 quotient
// bits per cycle; each digit character is then read from the digit stack's registered
// read port and loaded into the response register, after a leading '-' when negative;
// a response that is not taken holds those loads. Requests queue two deep ahead of the
// divider; the response register lets the next character be prepared while one waits.

module integer_to_radix_text
   import itrt_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [RADIX_W-1:0]     req_radix,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic                   rsp_last
);

   localparam int JOB_W = VALUE_WIDTH + $bits(job_ctl_type);

   // front: radix clamp, sign decision, magnitude
   logic                   push_valid, push_ready;
   logic [VALUE_WIDTH-1:0] push_mag;
   job_ctl_type            push_ctl;

   // back side of the job queue
   logic                   job_valid, job_ready;
   logic [JOB_W-1:0]       job_data;
   logic [VALUE_WIDTH-1:0] job_mag;
   job_ctl_type            job_ctl;

   itrt_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .req_radix  (req_radix),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_mag   (push_mag),
      .push_ctl   (push_ctl)
   );

   itrt_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_mag, push_ctl}),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (job_data)
   );

   assign job_mag = job_data[JOB_W-1 -: VALUE_WIDTH];
   assign job_ctl = job_data[$bits(job_ctl_type)-1:0];

   // back: digit divider, digit stack, character emission
   itrt_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_ready    (job_ready),
      .job_mag      (job_mag),
      .job_ctl      (job_ctl),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

@@ sv/itrt_ram.sv @@
module itrt_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/itrt_queue.sv @@
module itrt_queue
   import itrt_pkg::*;
#(
   parameter int DATA_W = 39
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int QIW = $clog2(QUEUE_DEPTH);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [QIW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QIW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QIW:0]      count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (QIW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/itrt_front.sv @@
module itrt_front
   import itrt_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [RADIX_W-1:0]     req_radix,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [VALUE_WIDTH-1:0] push_mag,
   output job_ctl_type            push_ctl
);

   logic [RADIX_W-1:0] radix_sat;
   logic               neg;

   // saturate base into 2..36
   always_comb begin
      radix_sat = req_radix;
      if (req_radix < RADIX_MIN) begin
         radix_sat = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         radix_sat = RADIX_MAX;
      end
   end

   // only base ten is signed
   assign neg = (radix_sat == DEC_BASE) && req_value[VALUE_WIDTH-1];

   assign push_mag       = neg ? (VALUE_WIDTH'(0) - req_value) : req_value;
   assign push_ctl.neg   = neg;
   assign push_ctl.radix = radix_sat;
   assign push_valid     = req_valid;
   assign req_ready      = push_ready;

endmodule

@@ sv/itrt_back.sv @@
module itrt_back
   import itrt_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  logic [VALUE_WIDTH-1:0] job_mag,
   input  job_ctl_type            job_ctl,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic                   rsp_last
);

   localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_W  = CHUNKS * STEP_BITS;
   localparam int CNT_W  = $clog2(CHUNKS) + 1;
   localparam int AW     = $clog2(VALUE_WIDTH);

   state_type state_ff, state_in;

   logic [DIV_W-1:0]   div_ff, div_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   chunk_ff, chunk_in;
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      ptr_ff, ptr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [DIV_W-1:0]   step_div;
   logic [DIGIT_W-1:0] step_rem;
   logic [DIGIT_W:0]   trial;
   logic               chunk_done;
   logic               quot_zero;
   logic               slot_free;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [DIGIT_W-1:0] ram_rd_data;

   // restoring division, STEP_BITS quotient bits per cycle; div_ff turns into the quotient
   always_comb begin
      step_div = div_ff;
      step_rem = rem_ff;
      trial    = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial    = {step_rem, step_div[DIV_W-1]};
         step_div = {step_div[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            trial       = trial - {1'b0, radix_ff};
            step_div[0] = 1'b1;
         end
         step_rem = trial[DIGIT_W-1:0];
      end
   end

   assign chunk_done = (chunk_ff == CNT_W'(CHUNKS - 1));
   assign quot_zero  = (step_div == '0);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign job_ready  = (state_ff == S_IDLE);
   assign ram_wr_en  = (state_ff == S_DIV) && chunk_done;
   assign ram_rd_en  = (state_ff == S_READ);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (chunk_done && quot_zero) begin
               state_in = neg_ff ? S_SIGN : S_READ;
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (slot_free) begin
               state_in = (ptr_ff == '0) ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      div_in       = div_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      chunk_in     = chunk_ff;
      wr_ptr_in    = wr_ptr_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               div_in    = DIV_W'(job_mag);
               rem_in    = '0;
               radix_in  = job_ctl.radix;
               neg_in    = job_ctl.neg;
               chunk_in  = '0;
               wr_ptr_in = '0;
            end
         end
         S_DIV: begin
            div_in = step_div;
            rem_in = step_rem;
            if (chunk_done) begin
               chunk_in = '0;
               rem_in   = '0;
               if (quot_zero) begin
                  ptr_in = wr_ptr_ff;
               end else begin
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         S_READ: begin
         end
         S_LOAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(ram_rd_data);
               rsp_last_in  = (ptr_ff == '0);
               if (ptr_ff != '0) begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      neg_ff      <= neg_in;
      chunk_ff    <= chunk_in;
      wr_ptr_ff   <= wr_ptr_in;
      ptr_ff      <= ptr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit stack: written least significant first, read back top down
   itrt_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (VALUE_WIDTH)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (step_rem),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

@@ sv/itrt_checker.sv @@
module itrt_checker
   import itrt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_char_out,
   input logic              rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_last))
      else $error("response changed while stalled");

   // only digits, lower-case letters or minus come out
   a_rsp_charset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_out >= CH_ZERO && rsp_char_out <= 8'h39) ||
                    (rsp_char_out >= CH_LOWER_A && rsp_char_out <= 8'h7A) ||
                    (rsp_char_out == CH_MINUS))
      else $error("illegal character");

   // the sign never ends the text
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_out == CH_MINUS |-> !rsp_last)
      else $error("minus sign flagged last");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import itrt_pkg::*;

   localparam int VW = VALUE_WIDTH_DEF;

   // Held-off stretch on the response side, and the window of accepted
   // requests in which neither side idles.
   localparam int HOLD_AT        = 200;
   localparam int HOLD_CYCLES    = 600;
   localparam int BUSY_FIRST     = 260;
   localparam int BUSY_LAST      = 340;
   localparam int RANDOM_ITEMS   = 435;
   localparam int SETTLE_CYCLES  = 250;
   localparam int MAX_PRINTED    = 40;

   typedef struct {
      logic [VW-1:0]      value;
      logic [RADIX_W-1:0] radix;
      bit                 drain_first;   // wait for every character before offering
   } conv_request_type;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
      int                item;           // request number, for the log
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [VW-1:0]      req_value = '0;
   logic [RADIX_W-1:0] req_radix = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CHAR_W-1:0]  rsp_char_out;
   logic               rsp_last;

   conv_request_type pending_requests[$];
   text_char_type    expected_text[$];
   text_char_type    head_char;

   int error_count    = 0;
   int accepted_count = 0;
   bit req_taken      = 1'b0;   // request handshake seen at the last rising edge
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   integer_to_radix_text #(
      .VALUE_WIDTH(VW)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_radix    (req_radix),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string what);
      if (error_count < MAX_PRINTED) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   // Builds the text of one request and appends its characters, most
   // significant first, to the expected text.
   function automatic void predict_text(input logic [VW-1:0] value,
                                        input logic [RADIX_W-1:0] radix_in,
                                        input int item);
      logic [VW-1:0]     mag;
      logic [VW-1:0]     base;
      logic [VW-1:0]     d;
      logic [CHAR_W-1:0] digits[$];
      bit                neg;
      base = VW'(radix_in);
      // out-of-range bases saturate at either end
      if (base < VW'(RADIX_MIN)) begin
         base = VW'(RADIX_MIN);
      end
      if (base > VW'(RADIX_MAX)) begin
         base = VW'(RADIX_MAX);
      end
      mag = value;
      neg = 1'b0;
      // only base ten is signed; the most negative value wraps to its own magnitude
      if (base == VW'(DEC_BASE) && value[VW-1]) begin
         neg = 1'b1;
         mag = -value;
      end
      if (mag == '0) begin
         digits.push_back(CH_ZERO);
      end
      while (mag != '0) begin
         d = mag % base;
         if (d < VW'(DEC_BASE)) begin
            digits.push_back(CH_ZERO + CHAR_W'(d));
         end else begin
            digits.push_back(CH_LOWER_A + CHAR_W'(d) - CHAR_W'(DEC_BASE));
         end
         mag = mag / base;
      end
      if (neg) begin
         expected_text.push_back('{ch: CH_MINUS, last: 1'b0, item: item});
      end
      for (int k = digits.size() - 1; k >= 0; k--) begin
         expected_text.push_back('{ch: digits[k], last: (k == 0), item: item});
      end
   endfunction

   function automatic void queue_request(input logic [VW-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
      pending_requests.push_back('{value: value, radix: radix, drain_first: 1'b0});
   endfunction

   // Random request: values lean toward short texts, extremes and negatives;
   // bases lean toward 2, 10 and 16, with the odd out-of-range base.
   function automatic conv_request_type random_request();
      conv_request_type r;
      r.drain_first = 1'b0;
      case ($urandom_range(5))
         0, 1: r.value = VW'($urandom);
         2:    r.value = VW'($urandom_range(0, 40));
         3: begin
            if ($urandom_range(1)) begin
               r.value = {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 3));
            end else begin
               r.value = {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 3));
            end
         end
         4:       r.value = -VW'($urandom_range(1, 1000));
         default: r.value = VW'($urandom) >> $urandom_range(0, VW - 1);
      endcase
      case ($urandom_range(9))
         0:       r.radix = RADIX_MIN;
         1, 2:    r.radix = DEC_BASE;
         3:       r.radix = RADIX_W'(16);
         4:       r.radix = RADIX_W'($urandom_range(0, 63));
         default: r.radix = RADIX_W'($urandom_range(2, 36));
      endcase
      return r;
   endfunction

   // Both sides run flat out in the middle of the run.
   function automatic bit may_idle();
      return !(accepted_count >= BUSY_FIRST && accepted_count < BUSY_LAST);
   endfunction

   // Request driver: a new transaction is put up at the falling edge once the
   // previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_requests[0].drain_first && expected_text.size() != 0) begin
            req_valid <= 1'b0;
         end else if (may_idle() && $urandom_range(99) < 12) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_value <= pending_requests[0].value;
            req_radix <= pending_requests[0].radix;
            void'(pending_requests.pop_front());
         end
      end
   end

   // Response side ready: random back-pressure, plus one long hold-off so the
   // request queue fills and req_ready drops while requests keep coming.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(may_idle() && $urandom_range(99) < 12);
      end
   end

   // Monitor: predicts on each request transaction and checks each response
   // transaction against the oldest expected character.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            predict_text(req_value, req_radix, accepted_count);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               flag_mismatch($sformatf("char 0x%02h last %0b with nothing expected",
                                       rsp_char_out, rsp_last));
            end else begin
               head_char = expected_text.pop_front();
               if (rsp_char_out !== head_char.ch) begin
                  flag_mismatch($sformatf("request %0d: char 0x%02h, expected 0x%02h",
                                          head_char.item, rsp_char_out, head_char.ch));
               end
               if (rsp_last !== head_char.last) begin
                  flag_mismatch($sformatf("request %0d: last %0b, expected %0b",
                                          head_char.item, rsp_last, head_char.last));
               end
            end
         end
      end
   end

   initial begin
      // directed: zero, all-ones, both extremes, letter digits, clamped bases
      queue_request('0, RADIX_W'(10));
      queue_request('0, RADIX_MIN);
      queue_request('0, RADIX_MAX);
      queue_request('1, RADIX_W'(10));
      queue_request('1, RADIX_MIN);
      queue_request('1, RADIX_W'(16));
      queue_request('1, RADIX_MAX);
      queue_request('1, RADIX_W'(3));
      queue_request({1'b1, {(VW-1){1'b0}}}, RADIX_W'(10));
      queue_request({1'b1, {(VW-1){1'b0}}}, RADIX_MIN);
      queue_request({1'b0, {(VW-1){1'b1}}}, RADIX_W'(10));
      queue_request({1'b0, {(VW-1){1'b1}}}, RADIX_MAX);
      queue_request(VW'(35), RADIX_MAX);
      queue_request(VW'(9), RADIX_W'(10));
      queue_request(VW'(10), RADIX_W'(16));
      queue_request(VW'(1), RADIX_MIN);
      queue_request(VW'(255), RADIX_MIN);
      queue_request(-VW'(12345), RADIX_W'(10));
      queue_request(VW'(123456789), RADIX_W'(8));
      queue_request(VW'(32'hdeadbeef), RADIX_W'(16));
      // bases below two act as two, above thirty-six as thirty-six
      queue_request(VW'(5), RADIX_W'(0));
      queue_request(VW'(5), RADIX_W'(1));
      queue_request(VW'(1295), RADIX_W'(37));
      queue_request(VW'(1295), RADIX_W'(63));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pending_requests.push_back(random_request());
      end
      // two points where the sender waits for the block to drain
      pending_requests[120].drain_first = 1'b1;
      pending_requests[380].drain_first = 1'b1;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || req_valid);
      while (expected_text.size() != 0) begin
         @(negedge clock);
      end
      // anything after this is an unexpected response
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
sv/itrt_pkg.sv
sv/itrt_ram.sv
sv/itrt_queue.sv
sv/itrt_front.sv
sv/itrt_back.sv
sv/integer_to_radix_text.sv
sv/itrt_checker.sv
bench/testbench.sv
